/* sv/nec_pkg.sv */
// Package for the normalized entropy concentration block.
// Holds sizing constants, controller state type and command/status structs.
// No dependencies.
package nec_pkg;

    localparam int MAX_BARS_DEF      = 256;
    localparam int SAMPLE_BITS_DEF   = 32;
    localparam int LOG_FRAC_BITS_DEF = 16;

    localparam int TOTAL_W = 40;
    localparam int WSUM_W  = 61;
    localparam int CONC_W  = 17;
    localparam int VOL_W   = 32;
    localparam int ONE_Q16 = 65536;

    // Log unit operand select
    typedef enum logic [1:0] {
        LSRC_SAMPLE,
        LSRC_TOTAL,
        LSRC_COUNT
    } lsrc_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOG_V,
        ST_MUL,
        ST_ACC,
        ST_LOG_T,
        ST_DIV_Q,
        ST_LOG_M,
        ST_DIV_R,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic  capture;     // load input word
        logic  log_start;   // start log unit
        lsrc_t log_src;
        logic  mul_go;      // form v*L(v)
        logic  acc_go;      // accumulate sample
        logic  save_lt;     // keep L(T)
        logic  div_q_start; // S / T
        logic  save_norm;   // keep L(m)
        logic  div_r_start; // (h<<16) / L(m)
        logic  finish;      // form result, clear row
        logic  out_clear;   // output word taken
    } cmd_t;

    typedef struct packed {
        logic usable;
        logic last;
        logic defined;
        logic log_busy;
        logic div_busy;
        logic out_valid;
    } stat_t;

endpackage

/* sv/nec_ctrl.sv */
// Controller for the normalized entropy concentration block.
// Sequences log, multiply, accumulate and division steps. Uses nec_pkg.
module nec_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            out_ready,
    input  nec_pkg::stat_t  stat,
    output nec_pkg::cmd_t   cmd
);
    import nec_pkg::*;

    state_t state_reg, state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.log_src = LSRC_SAMPLE;
        in_ready   = 1'b0;
        cmd.out_clear = stat.out_valid && out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOG_V;
                end
            end
            ST_LOG_V:
            begin
                if (stat.usable)
                begin
                    cmd.log_start = 1'b1;
                    cmd.log_src   = LSRC_SAMPLE;
                    state_next    = ST_MUL;
                end
                else
                    state_next = ST_LOG_T;
            end
            ST_MUL:
            begin
                if (!stat.log_busy)
                begin
                    cmd.mul_go = 1'b1;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.acc_go = 1'b1;
                state_next = ST_LOG_T;
            end
            ST_LOG_T:
            begin
                if (!stat.last)
                    state_next = ST_IDLE;
                else if (!stat.defined)
                    state_next = ST_FINISH;
                else
                begin
                    cmd.log_start = 1'b1;
                    cmd.log_src   = LSRC_TOTAL;
                    cmd.div_q_start = 1'b1;
                    state_next    = ST_DIV_Q;
                end
            end
            ST_DIV_Q:
            begin
                if (!stat.log_busy && !stat.div_busy)
                begin
                    cmd.save_lt   = 1'b1;
                    cmd.log_start = 1'b1;
                    cmd.log_src   = LSRC_COUNT;
                    state_next    = ST_LOG_M;
                end
            end
            ST_LOG_M:
            begin
                if (!stat.log_busy)
                begin
                    cmd.save_norm = 1'b1;
                    state_next    = ST_DIV_R;
                end
            end
            ST_DIV_R:
            begin
                cmd.div_r_start = 1'b1;
                state_next      = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!stat.div_busy && (!stat.out_valid || out_ready))
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/nec_dp.sv */
// Datapath for the normalized entropy concentration block.
// Accumulators, serial log2 unit (one squaring per cycle), restoring divider
// (one quotient bit per cycle) and output register. Uses nec_pkg.
module nec_dp
#(
    parameter int MAX_BARS      = nec_pkg::MAX_BARS_DEF,
    parameter int SAMPLE_BITS   = nec_pkg::SAMPLE_BITS_DEF,
    parameter int LOG_FRAC_BITS = nec_pkg::LOG_FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [nec_pkg::VOL_W-1:0] volume,
    input  logic                          missing,
    input  logic                          last_bar,
    input  nec_pkg::cmd_t                 cmd,
    output nec_pkg::stat_t                stat,
    output logic                          out_valid,
    output logic [nec_pkg::CONC_W-1:0]    concentration,
    output logic                          undefined
);
    import nec_pkg::*;

    localparam int CNT_W  = $clog2(MAX_BARS + 1);
    localparam int E_W    = 6;
    localparam int LOG_W  = E_W + LOG_FRAC_BITS;
    localparam int FCNT_W = $clog2(LOG_FRAC_BITS + 1);
    localparam int DIV_W  = 64;
    localparam int DCNT_W = 7;
    localparam logic [63:0] SAMP_LIM = (64'd1 << SAMPLE_BITS) - 64'd1;
    localparam logic [WSUM_W-1:0] WSUM_MAX = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Captured input word
    logic [VOL_W-1:0] vol_reg;
    logic             usable_reg;
    logic             last_reg;

    // Row state
    logic [TOTAL_W-1:0] total_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [WSUM_W-1:0]  wsum_reg;
    logic               ovf_reg;

    logic [31:0]        samp_sat;
    logic               positive;

    assign positive = (volume != '0) && !volume[VOL_W-1];
    assign samp_sat = ({32'd0, vol_reg} > SAMP_LIM) ? SAMP_LIM[31:0] : vol_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            vol_reg    <= volume;
            last_reg   <= last_bar;
        end
    end

    // Usable flag: also folds the row-full check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            usable_reg <= 1'b0;
            ovf_reg    <= 1'b0;
        end
        else if (cmd.capture)
        begin
            usable_reg <= !missing && positive && (count_reg < CNT_W'(MAX_BARS));
            if (!missing && positive && (count_reg >= CNT_W'(MAX_BARS)))
                ovf_reg <= 1'b1;
        end
        else if (cmd.finish)
            ovf_reg <= 1'b0;
    end

    // Serial log2 unit
    logic [63:0]        lm_reg;
    logic [E_W-1:0]     le_reg;
    logic [LOG_FRAC_BITS-1:0] lf_reg;
    logic [FCNT_W-1:0]  lcnt_reg;
    logic               lbusy_reg;
    logic [63:0]        lx;
    logic [E_W-1:0]     lx_e;
    logic [63:0]        lsq;

    always_comb
    begin
        lx = 64'd0;
        case (cmd.log_src)
            LSRC_SAMPLE: lx = {32'd0, samp_sat};
            LSRC_TOTAL:  lx = {24'd0, total_reg};
            LSRC_COUNT:  lx = 64'(count_reg);
            default:     lx = 64'd0;
        endcase
    end

    // Leading one position
    always_comb
    begin
        lx_e = '0;
        for (int i = 0; i < 64; i++)
            if (lx[i])
                lx_e = E_W'(i);
    end

    assign lsq = (lm_reg[31:0] * lm_reg[31:0]) >> 31;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lbusy_reg <= 1'b0;
            lcnt_reg  <= '0;
        end
        else if (cmd.log_start)
        begin
            lbusy_reg <= 1'b1;
            lcnt_reg  <= FCNT_W'(LOG_FRAC_BITS);
        end
        else if (lbusy_reg)
        begin
            lcnt_reg <= lcnt_reg - 1'b1;
            if (lcnt_reg == FCNT_W'(1))
                lbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.log_start)
        begin
            le_reg <= lx_e;
            lf_reg <= '0;
            if (lx_e > E_W'(31))
                lm_reg <= lx >> (lx_e - E_W'(31));
            else
                lm_reg <= lx << (E_W'(31) - lx_e);
        end
        else if (lbusy_reg)
        begin
            lf_reg <= {lf_reg[LOG_FRAC_BITS-2:0], lsq[32]};
            lm_reg <= lsq[32] ? (lsq >> 1) : lsq;
        end
    end

    logic [LOG_W-1:0] lres;
    assign lres = {le_reg, lf_reg};

    // Sample term and accumulate
    logic [63:0] term_reg;
    logic [WSUM_W:0] wsum_add;
    logic [TOTAL_W:0] tot_add;

    assign wsum_add = {1'b0, wsum_reg} + (WSUM_W + 1)'(term_reg);
    assign tot_add  = {1'b0, total_reg} + (TOTAL_W + 1)'(samp_sat);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_go)
            term_reg <= samp_sat * 64'(lres);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            count_reg <= '0;
            wsum_reg  <= '0;
        end
        else if (cmd.finish)
        begin
            total_reg <= '0;
            count_reg <= '0;
            wsum_reg  <= '0;
        end
        else if (cmd.acc_go)
        begin
            count_reg <= count_reg + 1'b1;
            total_reg <= tot_add[TOTAL_W] ? TOTAL_MAX : tot_add[TOTAL_W-1:0];
            wsum_reg  <= (wsum_add[WSUM_W] || (term_reg[63:WSUM_W] != '0))
                         ? WSUM_MAX : wsum_add[WSUM_W-1:0];
        end
    end

    // Keep L(T), L(m)
    logic [LOG_W-1:0] lt_reg;
    logic [LOG_W-1:0] norm_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.save_lt)
            lt_reg <= lres;
        if (cmd.save_norm)
            norm_reg <= lres;
    end

    // Restoring divider, one bit per cycle
    logic [DIV_W-1:0]  dq_reg;
    logic [DIV_W-1:0]  drem_reg;
    logic [DIV_W-1:0]  dden_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic              dbusy_reg;
    logic [DIV_W:0]    dshift;
    logic [DIV_W-1:0]  h_val;

    assign dshift = {drem_reg, dq_reg[DIV_W-1]};
    assign h_val  = (64'(lt_reg) > dq_reg) ? (64'(lt_reg) - dq_reg) : 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
        end
        else if (cmd.div_q_start || cmd.div_r_start)
        begin
            dbusy_reg <= 1'b1;
            dcnt_reg  <= DCNT_W'(DIV_W);
        end
        else if (dbusy_reg)
        begin
            dcnt_reg <= dcnt_reg - 1'b1;
            if (dcnt_reg == DCNT_W'(1))
                dbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_q_start)
        begin
            dq_reg   <= 64'(wsum_reg);
            drem_reg <= '0;
            dden_reg <= 64'(total_reg);
        end
        else if (cmd.div_r_start)
        begin
            dq_reg   <= h_val << 16;
            drem_reg <= '0;
            dden_reg <= 64'(norm_reg);
        end
        else if (dbusy_reg)
        begin
            if (dshift >= {1'b0, dden_reg})
            begin
                drem_reg <= DIV_W'(dshift - {1'b0, dden_reg});
                dq_reg   <= {dq_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= dshift[DIV_W-1:0];
                dq_reg   <= {dq_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    // Output register
    logic defined;
    logic out_valid_reg;
    logic [CONC_W-1:0] conc_reg;
    logic undef_reg;

    assign defined = !ovf_reg && (count_reg >= CNT_W'(2)) && (total_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (cmd.out_clear)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            undef_reg <= !defined;
            if (!defined)
                conc_reg <= '0;
            else if (dq_reg >= 64'(ONE_Q16))
                conc_reg <= '0;
            else
                conc_reg <= CONC_W'(64'(ONE_Q16) - dq_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign concentration = conc_reg;
    assign undefined     = undef_reg;

    assign stat.usable    = usable_reg;
    assign stat.last      = last_reg;
    assign stat.defined   = defined;
    assign stat.log_busy  = lbusy_reg;
    assign stat.div_busy  = dbusy_reg;
    assign stat.out_valid = out_valid_reg;

endmodule

/* sv/normalized_entropy_concentration.sv */
// Normalized entropy concentration: a usable sample passes a serial log2
// (one squaring per cycle), a multiply and an accumulate before ready returns;
// a skipped one bypasses them. A defined row end adds two 64-bit divisions and
// the log2 of the count; the log2 of the total overlaps the first division.
// One word in flight at a time; result register frees the output side.
// rst_n asynchronously clears control state and the row accumulators.
module normalized_entropy_concentration
#(
    parameter int MAX_BARS      = nec_pkg::MAX_BARS_DEF,
    parameter int SAMPLE_BITS   = nec_pkg::SAMPLE_BITS_DEF,
    parameter int LOG_FRAC_BITS = nec_pkg::LOG_FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [nec_pkg::VOL_W-1:0]  volume,
    input  logic                              missing,
    input  logic                              last_bar,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [nec_pkg::CONC_W-1:0]        concentration,
    output logic                              undefined
);
    import nec_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    nec_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    nec_dp
    #(
        .MAX_BARS      (MAX_BARS),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .LOG_FRAC_BITS (LOG_FRAC_BITS)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .volume        (volume),
        .missing       (missing),
        .last_bar      (last_bar),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .concentration (concentration),
        .undefined     (undefined)
    );

    // Result value never exceeds one in Q1.16
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (concentration <= CONC_W'(ONE_Q16)))
        else $error("concentration above one");

    // Undefined results carry zero concentration
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && undefined) |-> (concentration == '0))
        else $error("undefined result not zero");

    // No input taken while log or divider unit is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!stat.log_busy && !stat.div_busy))
        else $error("input accepted during computation");

    // A row end never overwrites a pending result
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && out_valid) |-> out_ready)
        else $error("result overwritten");

endmodule
